FILE: rtl/core/cns_bopomofo_line_parser_core_defines.svh
// Assertion helpers shared by the parser core.
`ifndef CNS_BOPOMOFO_LINE_PARSER_CORE_DEFINES_SVH
`define CNS_BOPOMOFO_LINE_PARSER_CORE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define CNS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// Check that a condition implies another in the same cycle.
`define CNS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cns_bpmf_pkg.sv
package cns_bpmf_pkg;

  // Token queue depth between the classifier and the line parser.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [3:0] {
    K_HEX,
    K_TAB,
    K_NL,
    K_EOI,
    K_NEUTRAL,
    K_INITIAL,
    K_MEDIAL,
    K_FINAL,
    K_TONE,
    K_OTHER
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] val;
  } tok_t;

  typedef enum logic [1:0] {
    S_PLANE,
    S_CODE,
    S_SOUND,
    S_SKIP
  } stage_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PLANE = 2'd1;
  localparam logic [1:0] ST_CODE  = 2'd2;
  localparam logic [1:0] ST_SOUND = 2'd3;

endpackage

FILE: rtl/core/cns_bpmf_classify.sv
module cns_bpmf_classify (
  input  logic               [20:0] code_point,
  input  logic                      end_of_input,
  output cns_bpmf_pkg::tok_t        tok
);
  import cns_bpmf_pkg::*;

  always_comb begin
    tok.kind = K_OTHER;
    tok.val  = 6'd0;
    if (end_of_input) begin
      tok.kind = K_EOI;
    end else if (code_point == 21'h0000A) begin
      tok.kind = K_NL;
    end else if (code_point == 21'h00009) begin
      tok.kind = K_TAB;
    end else if (code_point >= 21'h00030 && code_point <= 21'h00039) begin
      tok.kind = K_HEX;
      tok.val  = 6'(code_point - 21'h00030);
    end else if (code_point >= 21'h00041 && code_point <= 21'h00046) begin
      tok.kind = K_HEX;
      tok.val  = 6'(code_point - 21'h00037);
    end else if (code_point == 21'h002D9) begin
      tok.kind = K_NEUTRAL;
      tok.val  = 6'd1;
    end else if (code_point == 21'h002C7) begin
      tok.kind = K_TONE;
      tok.val  = 6'd2;
    end else if (code_point == 21'h002CA) begin
      tok.kind = K_TONE;
      tok.val  = 6'd3;
    end else if (code_point == 21'h002CB) begin
      tok.kind = K_TONE;
      tok.val  = 6'd4;
    end else if (code_point >= 21'h03105 && code_point <= 21'h03119) begin
      tok.kind = K_INITIAL;
      tok.val  = 6'(code_point - 21'h03105 + 21'd5);
    end else if (code_point >= 21'h03127 && code_point <= 21'h03129) begin
      tok.kind = K_MEDIAL;
      tok.val  = 6'(code_point - 21'h03127 + 21'd39);
    end else if (code_point >= 21'h0311A && code_point <= 21'h03126) begin
      tok.kind = K_FINAL;
      tok.val  = 6'(code_point - 21'h0311A + 21'd26);
    end
  end

endmodule

FILE: rtl/core/cns_bpmf_queue.sv
`include "cns_bopomofo_line_parser_core_defines.svh"

module cns_bpmf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cns_bpmf_pkg::tok_t push_tok,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output cns_bpmf_pkg::tok_t head_tok
);
  import cns_bpmf_pkg::*;

  tok_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == (QAW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_tok   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `CNS_ASSERT_ALWAYS(a_count_bound, count <= (QAW+1)'(QDEPTH), "queue count above depth")
  `CNS_ASSERT_IMPLY(a_ptr_gap, count != (QAW+1)'(QDEPTH) && count != '0,
                    wr_ptr != rd_ptr, "queue pointers meet while partly filled")
  `CNS_ASSERT_IMPLY(a_full_head, full, head_valid, "queue full without a valid head")

endmodule

FILE: rtl/core/cns_bpmf_exec.sv
`include "cns_bopomofo_line_parser_core_defines.svh"

module cns_bpmf_exec (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  cns_bpmf_pkg::tok_t head_tok,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         status,
  output logic [23:0]        cns_code,
  output logic [23:0]        phonetic_code
);
  import cns_bpmf_pkg::*;

  stage_t      stage, stage_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [23:0] code_acc, code_acc_next;
  logic [23:0] sound_acc, sound_acc_next;
  logic [2:0]  symbol_order, symbol_order_next;
  logic        neutral, neutral_next;
  logic [2:0]  slot_count, slot_count_next;
  logic [1:0]  line_status, line_status_next;

  logic        emit;
  logic        out_free;
  logic [1:0]  res_status;
  logic [23:0] res_cns;
  logic [23:0] res_phon;

  function automatic logic [23:0] slot_put(input logic [23:0] acc, input logic [2:0] slots,
                                           input logic [5:0] v);
    logic [23:0] r;
    r = acc;
    if (slots < 3'd4) begin
      case (slots[1:0])
        2'd0:    r[23:18] = r[23:18] | v;
        2'd1:    r[17:12] = r[17:12] | v;
        2'd2:    r[11:6]  = r[11:6]  | v;
        default: r[5:0]   = r[5:0]   | v;
      endcase
    end
    return r;
  endfunction

  function automatic logic [2:0] slot_inc(input logic [2:0] slots);
    return (slots < 3'd4) ? slots + 3'd1 : slots;
  endfunction

  function automatic logic head_kind_ends_line();
    return head_valid && (head_tok.kind == K_NL || head_tok.kind == K_EOI);
  endfunction

  assign out_free = !result_valid || !result_stall;
  assign pop      = head_valid && (!emit || out_free);

  always_comb begin
    stage_next        = stage;
    digit_count_next  = digit_count;
    code_acc_next     = code_acc;
    sound_acc_next    = sound_acc;
    symbol_order_next = symbol_order;
    neutral_next      = neutral;
    slot_count_next   = slot_count;
    line_status_next  = line_status;

    if (head_kind_ends_line()) begin
      stage_next        = S_PLANE;
      digit_count_next  = 3'd0;
      code_acc_next     = 24'd0;
      sound_acc_next    = 24'd0;
      symbol_order_next = 3'd0;
      neutral_next      = 1'b0;
      slot_count_next   = 3'd0;
      line_status_next  = ST_OK;
    end else if (head_valid) begin
      case (stage)
        S_PLANE: begin
          if (head_tok.kind == K_HEX && digit_count < 3'd2) begin
            code_acc_next    = {code_acc[19:0], head_tok.val[3:0]};
            digit_count_next = digit_count + 3'd1;
          end else if (head_tok.kind == K_TAB && digit_count != 3'd0) begin
            stage_next       = S_CODE;
            digit_count_next = 3'd0;
          end else begin
            stage_next       = S_SKIP;
            line_status_next = ST_PLANE;
          end
        end
        S_CODE: begin
          if (head_tok.kind == K_HEX && digit_count < 3'd4) begin
            code_acc_next    = {code_acc[19:0], head_tok.val[3:0]};
            digit_count_next = digit_count + 3'd1;
          end else if (head_tok.kind == K_TAB && digit_count == 3'd4) begin
            stage_next = S_SOUND;
          end else begin
            stage_next       = S_SKIP;
            line_status_next = ST_CODE;
          end
        end
        S_SOUND: begin
          if (head_tok.kind == K_NEUTRAL && symbol_order == 3'd0) begin
            symbol_order_next = 3'd1;
            neutral_next      = 1'b1;
          end else if ((head_tok.kind == K_INITIAL && symbol_order < 3'd2) ||
                       (head_tok.kind == K_MEDIAL && symbol_order < 3'd3) ||
                       (head_tok.kind == K_FINAL && symbol_order < 3'd4) ||
                       ((head_tok.kind == K_TONE || head_tok.kind == K_NEUTRAL) &&
                        symbol_order < 3'd5 && !neutral)) begin
            case (head_tok.kind)
              K_INITIAL: symbol_order_next = 3'd2;
              K_MEDIAL:  symbol_order_next = 3'd3;
              K_FINAL:   symbol_order_next = 3'd4;
              default:   symbol_order_next = 3'd5;
            endcase
            sound_acc_next  = slot_put(sound_acc, slot_count, head_tok.val);
            slot_count_next = slot_inc(slot_count);
          end else begin
            stage_next       = S_SKIP;
            line_status_next = ST_SOUND;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    emit       = 1'b0;
    res_status = ST_OK;
    res_cns    = 24'd0;
    res_phon   = 24'd0;
    // close the line, emit unless it is an empty last line
    if (head_kind_ends_line() &&
        !(head_tok.kind == K_EOI && stage == S_PLANE && digit_count == 3'd0)) begin
      emit = 1'b1;
      case (stage)
        S_PLANE: res_status = ST_PLANE;
        S_CODE:  res_status = ST_CODE;
        S_SKIP:  res_status = line_status;
        default: res_status = ST_OK;
      endcase
      if (res_status == ST_OK) begin
        res_cns  = code_acc;
        res_phon = neutral ? slot_put(sound_acc, slot_count, 6'd1) : sound_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage        <= S_PLANE;
      digit_count  <= 3'd0;
      code_acc     <= 24'd0;
      sound_acc    <= 24'd0;
      symbol_order <= 3'd0;
      neutral      <= 1'b0;
      slot_count   <= 3'd0;
      line_status  <= ST_OK;
    end else if (pop) begin
      stage        <= stage_next;
      digit_count  <= digit_count_next;
      code_acc     <= code_acc_next;
      sound_acc    <= sound_acc_next;
      symbol_order <= symbol_order_next;
      neutral      <= neutral_next;
      slot_count   <= slot_count_next;
      line_status  <= line_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= pop && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pop && emit) begin
      status        <= res_status;
      cns_code      <= res_cns;
      phonetic_code <= res_phon;
    end
  end

  `CNS_ASSERT_IMPLY(a_emit_room, pop && emit, out_free, "line closed with result register busy")
  `CNS_ASSERT_IMPLY(a_skip_status, stage == S_SKIP, line_status != ST_OK,
                    "skipped line carries accepted status")
  `CNS_ASSERT_ALWAYS(a_slot_bound, slot_count <= 3'd4 && symbol_order <= 3'd5,
                     "phonetic slot or order counter out of range")

endmodule

FILE: rtl/core/cns_bopomofo_line_parser_core.sv
// A newline or end of text is queued; the parser registers its result when it pops it.
// Throughput: one code point per cycle while code_stall is low; the parser sets the rate.
// A 4-entry token queue lets intake continue while a result waits on result_stall.
// Reset (rst, synchronous, active high) empties the queue, drops any pending result
// and puts the parser at line start in the plane field.
module cns_bopomofo_line_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        code_valid,
  output logic        code_stall,
  input  logic [20:0] code_point,
  input  logic        end_of_input,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [23:0] cns_code,
  output logic [23:0] phonetic_code
);
  import cns_bpmf_pkg::*;

  tok_t in_tok;
  tok_t head_tok;
  logic q_full;
  logic head_valid;
  logic pop;

  // Front: classify each code point into a token kind plus a hex or symbol value.
  cns_bpmf_classify u_classify (
    .code_point   (code_point),
    .end_of_input (end_of_input),
    .tok          (in_tok)
  );

  // Hold tokens here; stall the source only when the queue is full.
  assign code_stall = q_full;

  cns_bpmf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (code_valid),
    .push_tok   (in_tok),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  // Back: advance the line state one token a cycle, holding a newline or end of text
  // until the output register has room, then transfer its one result into it.
  cns_bpmf_exec u_exec (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_tok      (head_tok),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .cns_code      (cns_code),
    .phonetic_code (phonetic_code)
  );

endmodule
